// ----- design/pia_pkg.sv -----
// Package for the positional insert/erase array: item structs, opcode,
// status and state codes, and default sizes. No dependencies.
`timescale 1ns / 1ps

package pia_pkg;

    // Default sizes; DEPTH_DEF and DATA_WIDTH_DEF are handed to the top level as parameter defaults
    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int GROUP_SIZE     = 16;
    localparam int POS_W          = 8;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_ERASE  = 2'd2,
        OP_READ   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ILLEGAL = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_GATHER = 2'd1,
        S_APPLY  = 2'd2
    } state_t;

    typedef struct packed {
        opcode_t          opcode;
        logic [POS_W-1:0] position;
        logic [31:0]      element;
    } in_item_t;

    typedef struct packed {
        logic [31:0] word_out;
        status_t     status;
        logic [8:0]  count;
        logic        is_empty;
    } out_item_t;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic             apply;
        opcode_t          op;
        logic [POS_W-1:0] pos;
    } cell_ctrl_t;

endpackage

// ----- design/pia_cell.sv -----
// One storage cell of the insertion array: holds a word, loads it, or
// takes it from the left or right neighbor. Depends on pia_pkg.
`timescale 1ns / 1ps

module pia_cell #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                         aclk,
    input  pia_pkg::cell_ctrl_t          ctrl,
    input  logic [$clog2(DEPTH+1)-1:0]   count,
    input  logic [DATA_WIDTH-1:0]        elem,
    input  logic [DATA_WIDTH-1:0]        left_data,
    input  logic [DATA_WIDTH-1:0]        right_data,
    output logic [DATA_WIDTH-1:0]        data_out,
    output logic [DATA_WIDTH-1:0]        hit_data
);
    import pia_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [XW-1:0] IDX      = XW'(INDEX);
    localparam logic [XW-1:0] IDX_NEXT = XW'(INDEX + 1);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic [XW-1:0]         pos_x;
    logic [XW-1:0]         count_x;

    assign pos_x   = XW'(ctrl.pos);
    assign count_x = XW'(count);

    // Pick this cell's next word from the broadcast command
    always_comb begin
        data_next = data_reg;
        if (ctrl.apply) begin
            unique case (ctrl.op)
                OP_APPEND: begin
                    if (IDX == count_x) data_next = elem;
                end
                OP_INSERT: begin
                    if (IDX == pos_x) begin
                        data_next = elem;
                    end else if (IDX > pos_x && IDX <= count_x) begin
                        data_next = left_data;
                    end
                end
                OP_ERASE: begin
                    if (IDX >= pos_x && IDX_NEXT < count_x) data_next = right_data;
                end
                OP_READ: begin
                    data_next = data_reg;
                end
                default: data_next = data_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;
    // Present the word only when the position selects this cell
    assign hit_data = (IDX == pos_x) ? data_reg : '0;

endmodule

// ----- design/pia_gather.sv -----
// Registered OR tree that collects the selected cell's word from the row.
// First level is registered per group, second level is combinational.
// Depends on pia_pkg.
`timescale 1ns / 1ps

module pia_gather #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  capture,
    input  logic [DATA_WIDTH-1:0] hits [DEPTH],
    output logic [DATA_WIDTH-1:0] word
);
    import pia_pkg::*;

    localparam int NGROUP = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

    logic [DATA_WIDTH-1:0] group_reg  [NGROUP];
    logic [DATA_WIDTH-1:0] group_next [NGROUP];

    // Reduce each group of cells
    always_comb begin
        for (int g = 0; g < NGROUP; g++) begin
            group_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                if (g * GROUP_SIZE + k < DEPTH) begin
                    group_next[g] = group_next[g] | hits[g * GROUP_SIZE + k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (capture) begin
            group_reg <= group_next;
        end
    end

    // Combine the group results
    always_comb begin
        word = '0;
        for (int g = 0; g < NGROUP; g++) begin
            word = word | group_reg[g];
        end
    end

endmodule

// ----- design/positional_insert_erase_array.sv -----
// Top level of the positional insert/erase array: item registers, control
// sequencer, row of pia_cell instances and the pia_gather readout tree.
// Depends on pia_pkg, pia_cell, pia_gather.
//
// Usage:
//   s_valid/s_ready/s_data carry one operation item (append, insert at an
//   index, erase at an index, read at an index). m_valid/m_ready/m_data
//   return exactly one result item per operation: the word read or erased,
//   a status, and the count after the operation.
//   The item is first captured, then the selected word is registered through
//   the group OR tree, then the cells are updated in parallel (each affected
//   cell shifts from its neighbor at once) and the result register is written.
//   A new item is accepted only once the previous one has finished its update.
//   Stall: a result waits in the output register while m_ready is low; the
//   next item is still accepted and is held before its update step until
//   the output register is free, so nothing is lost or overwritten.
//   Reset: the count, the state and the valid flag clear. Cell contents
//   stay undefined; only entries below the count are ever returned.
`timescale 1ns / 1ps

module positional_insert_erase_array #(
    parameter int DEPTH      = pia_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = pia_pkg::DATA_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pia_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pia_pkg::out_item_t m_data
);
    import pia_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    state_t                state_reg;
    state_t                state_next;
    opcode_t               op_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [DATA_WIDTH-1:0] elem_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  m_valid_reg;
    out_item_t             m_data_reg;

    logic                  accept;
    logic                  capture;
    logic                  apply;
    logic                  full;
    status_t               status;
    logic [DATA_WIDTH-1:0] gathered;
    logic [DATA_WIDTH-1:0] word;
    cell_ctrl_t            ctrl;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DATA_WIDTH-1:0] hits      [DEPTH];

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);

    // Sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and step strobes
    always_comb begin
        state_next = state_reg;
        capture    = 1'b0;
        apply      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) state_next = S_GATHER;
            end
            S_GATHER: begin
                capture = 1'b1;
                if (!m_valid_reg || m_ready) state_next = S_APPLY;
            end
            S_APPLY: begin
                apply      = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold the accepted item
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_data.opcode;
            pos_reg  <= s_data.position;
            elem_reg <= DATA_WIDTH'(s_data.element);
        end
    end

    // Decide status and new count
    assign full = (count_reg == FULL_COUNT);

    always_comb begin
        status     = ST_OK;
        count_next = count_reg;
        word       = '0;
        priority if (op_reg == OP_APPEND) begin
            if (full) begin
                status = ST_FULL;
            end else begin
                count_next = count_reg + 1'b1;
            end
        end else if (XW'(pos_reg) >= XW'(count_reg)) begin
            status = ST_ILLEGAL;
        end else if (op_reg == OP_INSERT) begin
            if (full) begin
                status = ST_FULL;
            end else begin
                count_next = count_reg + 1'b1;
            end
        end else if (op_reg == OP_ERASE) begin
            word       = gathered;
            count_next = count_reg - 1'b1;
        end else begin
            word = gathered;
        end
    end

    // Count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (apply) begin
            count_reg <= count_next;
        end
    end

    // Output register: load on the update step, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (apply) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (apply) begin
            m_data_reg.word_out <= 32'(word);
            m_data_reg.status   <= status;
            m_data_reg.count    <= 9'(count_next);
            m_data_reg.is_empty <= (count_next == '0);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Broadcast command to the row
    assign ctrl.apply = apply && (status == ST_OK);
    assign ctrl.op    = op_reg;
    assign ctrl.pos   = pos_reg;

    // Row of cells, each linked to its neighbors
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_in;
        logic [DATA_WIDTH-1:0] right_in;

        if (i == 0) begin : g_first
            assign left_in = '0;
        end else begin : g_mid_l
            assign left_in = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_in = '0;
        end else begin : g_mid_r
            assign right_in = cell_data[i+1];
        end

        pia_cell #(
            .DEPTH      (DEPTH),
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (i)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .elem       (elem_reg),
            .left_data  (left_in),
            .right_data (right_in),
            .data_out   (cell_data[i]),
            .hit_data   (hits[i])
        );
    end

    pia_gather #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_gather (
        .aclk    (aclk),
        .capture (capture),
        .hits    (hits),
        .word    (gathered)
    );

endmodule

// ----- design/pia_checker.sv -----
// Port-level checks for positional_insert_erase_array, attached by bind.
// Depends on pia_pkg.
`timescale 1ns / 1ps

module pia_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input pia_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input pia_pkg::out_item_t m_data
);
    import pia_pkg::*;

    // Stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Empty flag tracks the reported count
    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.is_empty == (m_data.count == 9'd0)))
        else $error("is_empty disagrees with count");

    // Rejected operations return a zero word
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.word_out == 32'd0)
        else $error("rejected operation returned data");

    // One item in work at a time: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while another is in work");

    // Reset leaves no result pending
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind positional_insert_erase_array pia_checker u_pia_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- bench/list_op_checker.sv -----
// Checker for the positional insert/erase array: watches both item channels,
// keeps a shadow copy of the ordered list and compares every result item.
// Depends on pia_pkg.
`timescale 1ns / 1ps

module list_op_checker #(
    parameter int LIST_DEPTH = pia_pkg::DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  pia_pkg::in_item_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  pia_pkg::out_item_t m_data,
    output int                 fail_count,
    output int                 pending,
    output int                 list_len,
    output int                 checked
);
    import pia_pkg::*;

    // Shadow list and its length, updated once per accepted operation
    logic [31:0] shadow_list [0:LIST_DEPTH-1];
    int          shadow_len;
    out_item_t   expected_results [$];
    int          mismatches;
    int          compared;

    // Apply one operation to the shadow list and return the result it gives
    function automatic out_item_t apply_list_op(in_item_t op_in);
        out_item_t res;
        int        p;
        res        = '0;
        res.status = ST_OK;
        p          = op_in.position;
        if (op_in.opcode == OP_APPEND) begin
            if (shadow_len >= LIST_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                shadow_list[shadow_len] = op_in.element;
                shadow_len++;
            end
        end else if (p >= shadow_len) begin
            // index at or past the end: reject and leave the list alone
            res.status = ST_ILLEGAL;
        end else begin
            case (op_in.opcode)
                OP_INSERT: begin
                    if (shadow_len >= LIST_DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        for (int j = shadow_len; j > p; j--)
                            shadow_list[j] = shadow_list[j-1];
                        shadow_list[p] = op_in.element;
                        shadow_len++;
                    end
                end
                OP_ERASE: begin
                    res.word_out = shadow_list[p];
                    for (int j = p; j + 1 < shadow_len; j++)
                        shadow_list[j] = shadow_list[j+1];
                    shadow_len--;
                end
                default: begin
                    res.word_out = shadow_list[p];
                end
            endcase
        end
        res.count    = 9'(shadow_len);
        res.is_empty = (shadow_len == 0);
        return res;
    endfunction

    // Predict on accepted operations, compare on accepted results
    always @(posedge aclk) begin
        out_item_t want;
        out_item_t predicted;
        if (!aresetn) begin
            shadow_len = 0;
            expected_results.delete();
        end else begin
            if (s_valid && s_ready) begin
                predicted = apply_list_op(s_data);
                expected_results.insert(expected_results.size(), predicted);
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result item with none expected: expected nothing, got %h",
                             $time, m_data);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    compared++;
                    if (m_data.word_out !== want.word_out) begin
                        $display("%0t: word_out expected %h got %h",
                                 $time, want.word_out, m_data.word_out);
                        mismatches++;
                    end
                    if (m_data.status !== want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, m_data.status);
                        mismatches++;
                    end
                    if (m_data.count !== want.count) begin
                        $display("%0t: count expected %0d got %0d",
                                 $time, want.count, m_data.count);
                        mismatches++;
                    end
                    if (m_data.is_empty !== want.is_empty) begin
                        $display("%0t: is_empty expected %b got %b",
                                 $time, want.is_empty, m_data.is_empty);
                        mismatches++;
                    end
                end
            end
        end
        fail_count <= mismatches;
        pending    <= expected_results.size();
        list_len   <= shadow_len;
        checked    <= compared;
    end

endmodule

// ----- bench/testbench.sv -----
// Top of the bench for the positional insert/erase array: clock, reset,
// operation stimulus, result-side backpressure, watchdog and verdict.
// Depends on pia_pkg, positional_insert_erase_array and list_op_checker.
`timescale 1ns / 1ps

module testbench;
    import pia_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEF;
    localparam int LONG_HOLD  = 300;
    localparam int IDLE_LIMIT = 3000;

    typedef enum {
        PH_DIRECTED, PH_FILL, PH_FULL, PH_HOLD, PH_DRAIN, PH_NOISE, PH_WALK, PH_QUIET
    } phase_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    phase_t    phase = PH_DIRECTED;
    int        fail_count;
    int        pending;
    int        list_len;
    int        checked;
    int        ops_sent  = 0;
    int        peak_len  = 0;
    int        idle_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    positional_insert_erase_array #(
        .DEPTH      (LIST_DEPTH),
        .DATA_WIDTH (DATA_WIDTH_DEF)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    list_op_checker #(
        .LIST_DEPTH (LIST_DEPTH)
    ) list_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending),
        .list_len   (list_len),
        .checked    (checked)
    );

    function automatic in_item_t op_item(opcode_t op, int pos, logic [31:0] word);
        in_item_t it;
        it.opcode   = op;
        it.position = 8'(pos);
        it.element  = word;
        return it;
    endfunction

    // Offer one item and hold it until accepted, then maybe idle a burst
    task automatic push_op(input in_item_t it);
        bit may_idle;
        may_idle = (phase != PH_HOLD) && (phase != PH_QUIET);
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ops_sent++;
        if (list_len > peak_len) peak_len = list_len;
        if (may_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    // Pick an opcode by weight and an index aimed mostly inside the list
    task automatic push_weighted(input int w_app, input int w_ins, input int w_era,
                                 input int w_rd);
        in_item_t it;
        int       r;
        int       len_now;
        r       = $urandom_range(0, w_app + w_ins + w_era + w_rd - 1);
        len_now = list_len;
        if (r < w_app)
            it.opcode = OP_APPEND;
        else if (r < w_app + w_ins)
            it.opcode = OP_INSERT;
        else if (r < w_app + w_ins + w_era)
            it.opcode = OP_ERASE;
        else
            it.opcode = OP_READ;
        case ($urandom_range(0, 9))
            0: it.position = 8'($urandom_range(0, 255));
            1: it.position = (len_now > 255) ? 8'hFF : 8'(len_now);
            default: it.position = (len_now == 0) ? 8'd0 : 8'($urandom_range(0, len_now - 1));
        endcase
        case ($urandom_range(0, 15))
            0: it.element = 32'h0000_0000;
            1: it.element = 32'hFFFF_FFFF;
            default: it.element = $urandom;
        endcase
        push_op(it);
    endtask

    // Stop offering and hold until every outstanding result has come back
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Result side: random stall bursts, one long hold-off, none at the end
    initial begin : receiver
        bit held_long;
        held_long = 1'b0;
        wait (aresetn);
        forever begin
            if (phase == PH_HOLD && !held_long) begin
                held_long = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (phase == PH_QUIET) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else if ($urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    // Abort when neither channel moves an item for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int guard;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty list, both ends, illegal indexes, ignored position
        push_op(op_item(OP_READ,   0,   32'h1111_1111));
        push_op(op_item(OP_ERASE,  0,   32'h2222_2222));
        push_op(op_item(OP_INSERT, 0,   32'h3333_3333));
        push_op(op_item(OP_READ,   255, 32'h0));
        push_op(op_item(OP_APPEND, 0,   32'hFFFF_FFFF));
        push_op(op_item(OP_APPEND, 0,   32'h0000_0000));
        push_op(op_item(OP_APPEND, 0,   32'h1234_5678));
        push_op(op_item(OP_INSERT, 0,   32'hA5A5_A5A5));
        push_op(op_item(OP_INSERT, 3,   32'h8000_0001));
        push_op(op_item(OP_INSERT, 5,   32'hDEAD_BEEF));
        push_op(op_item(OP_INSERT, 255, 32'hCAFE_F00D));
        push_op(op_item(OP_READ,   0,   32'h0));
        push_op(op_item(OP_READ,   4,   32'h0));
        push_op(op_item(OP_READ,   5,   32'h0));
        push_op(op_item(OP_READ,   255, 32'h0));
        push_op(op_item(OP_ERASE,  4,   32'h0));
        push_op(op_item(OP_ERASE,  0,   32'h0));
        push_op(op_item(OP_ERASE,  1,   32'h0));
        push_op(op_item(OP_ERASE,  255, 32'h0));
        push_op(op_item(OP_APPEND, 255, 32'h5A5A_5A5A));
        push_op(op_item(OP_ERASE,  0,   32'h0));
        push_op(op_item(OP_ERASE,  0,   32'h0));
        push_op(op_item(OP_ERASE,  0,   32'h0));
        push_op(op_item(OP_READ,   0,   32'h0));
        wait_for_results();

        // Grow the list until it is full
        phase <= PH_FILL;
        guard = 0;
        while (list_len < LIST_DEPTH && guard < 900) begin
            push_weighted(5, 3, 1, 2);
            guard++;
        end
        wait_for_results();

        // Work at capacity: rejected appends and inserts, erase and refill
        phase <= PH_FULL;
        repeat (150) push_weighted(3, 3, 1, 3);
        wait_for_results();

        // Long receiver hold-off while operations keep coming
        phase <= PH_HOLD;
        repeat (30) push_weighted(2, 2, 2, 2);
        wait_for_results();

        // Shrink the list back to empty
        phase <= PH_DRAIN;
        guard = 0;
        while (list_len > 0 && guard < 900) begin
            push_weighted(0, 1, 6, 1);
            guard++;
        end
        wait_for_results();

        // Unaimed items: any opcode, any index, any word
        phase <= PH_NOISE;
        repeat (150)
            push_op(op_item(opcode_t'($urandom_range(0, 3)), $urandom_range(0, 255), $urandom));
        wait_for_results();

        // Random walk around a partly filled list
        phase <= PH_WALK;
        repeat (250) push_weighted(2, 1, 3, 2);
        wait_for_results();

        // Last stretch with no idling on either side
        phase <= PH_QUIET;
        repeat (200) push_weighted(2, 2, 2, 2);
        wait_for_results();
        repeat (20) @(posedge aclk);

        $display("Sent %0d operations over directed, fill, full, hold-off, drain, noise",
                 ops_sent);
        $display("and streaming phases; %0d results compared, peak list length %0d.",
                 checked, peak_len);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- positional_insert_erase_array.f -----
design/pia_pkg.sv
design/pia_cell.sv
design/pia_gather.sv
design/positional_insert_erase_array.sv
design/pia_checker.sv
bench/list_op_checker.sv
bench/testbench.sv
